/* src/sha256mh_pkg.sv */
// Shared types, constants and helper functions for the SHA-256 message hasher.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package sha256mh_pkg;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS = 8;
  localparam int unsigned ROUNDS = 64;

  localparam logic [5:0] ROUND_LAST = 6'(ROUNDS - 1);
  localparam logic [2:0] DIGEST_LAST = 3'(HASH_WORDS - 1);
  localparam logic [2:0] FULL_WORD_BYTES = 3'd4;
  localparam logic [31:0] PAD_MARKER = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_done;
  } digest_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PAD_ZERO,
    PAD_MARK,
    PAD_LEN_HI,
    PAD_LEN_LO
  } pad_sel_t;

  typedef struct packed {
    logic       push_msg;
    logic       push_pad;
    pad_sel_t   pad_sel;
    logic       round_en;
    logic [5:0] round_idx;
    logic       update_hash;
    logic       clear_hash;
    logic [2:0] out_index;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pos_14;
    logic pos_15;
  } dp_status_t;

  localparam logic [31:0] IV_TABLE [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TABLE [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* src/sha256mh_ctrl.sv */
// Controller state machine for the SHA-256 message hasher.
// Sequences word loading, padding, compression rounds and digest output.
// Depends on sha256mh_pkg.
module sha256mh_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    msg_valid,
  input  sha256mh_pkg::msg_t      msg,
  output logic                    msg_ready,
  output logic                    digest_valid,
  input  logic                    digest_ready,
  input  sha256mh_pkg::dp_status_t status,
  output sha256mh_pkg::ctrl_cmd_t cmd
);

  sha256mh_pkg::state_t state;
  sha256mh_pkg::state_t state_next;
  logic [5:0] round_count;
  logic [2:0] out_index;
  logic       finishing;
  logic       marker_pending;
  logic       hi_done;
  logic       len_done;
  logic       full_last;

  assign full_last = msg.end_of_message && (msg.valid_bytes >= sha256mh_pkg::FULL_WORD_BYTES);

  always_comb begin
    state_next = state;
    unique case (state)
      sha256mh_pkg::ST_IDLE: begin
        if (msg_valid) begin
          if (status.pos_15) begin
            state_next = sha256mh_pkg::ST_ROUND;
          end else if (msg.end_of_message) begin
            state_next = sha256mh_pkg::ST_PAD;
          end
        end
      end
      sha256mh_pkg::ST_PAD: begin
        if (status.pos_15) begin
          state_next = sha256mh_pkg::ST_ROUND;
        end
      end
      sha256mh_pkg::ST_ROUND: begin
        if (round_count == sha256mh_pkg::ROUND_LAST) begin
          state_next = sha256mh_pkg::ST_UPDATE;
        end
      end
      sha256mh_pkg::ST_UPDATE: begin
        priority if (!finishing) begin
          state_next = sha256mh_pkg::ST_IDLE;
        end else if (len_done) begin
          state_next = sha256mh_pkg::ST_OUT;
        end else begin
          state_next = sha256mh_pkg::ST_PAD;
        end
      end
      sha256mh_pkg::ST_OUT: begin
        if (digest_ready && (out_index == sha256mh_pkg::DIGEST_LAST)) begin
          state_next = sha256mh_pkg::ST_IDLE;
        end
      end
      default: state_next = sha256mh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    msg_ready = 1'b0;
    digest_valid = 1'b0;
    cmd = '0;
    cmd.pad_sel = sha256mh_pkg::PAD_ZERO;
    cmd.round_idx = round_count;
    cmd.out_index = out_index;
    unique case (state)
      sha256mh_pkg::ST_IDLE: begin
        msg_ready = 1'b1;
        cmd.push_msg = msg_valid;
      end
      sha256mh_pkg::ST_PAD: begin
        cmd.push_pad = 1'b1;
        priority if (marker_pending) begin
          cmd.pad_sel = sha256mh_pkg::PAD_MARK;
        end else if (status.pos_14) begin
          cmd.pad_sel = sha256mh_pkg::PAD_LEN_HI;
        end else if (status.pos_15 && hi_done) begin
          cmd.pad_sel = sha256mh_pkg::PAD_LEN_LO;
        end else begin
          cmd.pad_sel = sha256mh_pkg::PAD_ZERO;
        end
      end
      sha256mh_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
      end
      sha256mh_pkg::ST_UPDATE: begin
        cmd.update_hash = 1'b1;
      end
      sha256mh_pkg::ST_OUT: begin
        digest_valid = 1'b1;
        cmd.clear_hash = digest_ready && (out_index == sha256mh_pkg::DIGEST_LAST);
      end
      default: begin
        msg_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256mh_pkg::ST_IDLE;
      round_count <= '0;
      out_index <= '0;
      finishing <= 1'b0;
      marker_pending <= 1'b0;
      hi_done <= 1'b0;
      len_done <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.round_en) begin
        round_count <= round_count + 6'd1;
      end
      if (digest_valid && digest_ready) begin
        out_index <= out_index + 3'd1;
      end
      if (cmd.push_msg) begin
        finishing <= msg.end_of_message;
        marker_pending <= full_last;
        hi_done <= 1'b0;
        len_done <= 1'b0;
      end
      if (cmd.push_pad) begin
        unique case (cmd.pad_sel)
          sha256mh_pkg::PAD_MARK:   marker_pending <= 1'b0;
          sha256mh_pkg::PAD_LEN_HI: hi_done <= 1'b1;
          sha256mh_pkg::PAD_LEN_LO: len_done <= 1'b1;
          sha256mh_pkg::PAD_ZERO:   hi_done <= hi_done;
          default:                  hi_done <= hi_done;
        endcase
      end
      if (cmd.clear_hash) begin
        finishing <= 1'b0;
      end
    end
  end

endmodule

/* src/sha256mh_datapath.sv */
// Datapath for the SHA-256 message hasher: block buffer and schedule window,
// working variables, chaining value, word position and bit count.
// Depends on sha256mh_pkg.
module sha256mh_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  sha256mh_pkg::msg_t       msg,
  input  sha256mh_pkg::ctrl_cmd_t  cmd,
  output sha256mh_pkg::dp_status_t status,
  output logic [31:0]              hash_word
);

  logic [31:0] sched [sha256mh_pkg::BLOCK_WORDS];
  logic [31:0] vars [sha256mh_pkg::HASH_WORDS];
  logic [31:0] hash [sha256mh_pkg::HASH_WORDS];
  logic [3:0]  pos;
  logic [63:0] bit_count;

  logic [2:0]  nb_eff;
  logic [31:0] keep_mask;
  logic [31:0] marker;
  logic [31:0] msg_word;
  logic [31:0] pad_word;
  logic [31:0] push_word;
  logic        push;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] sched_new;

  always_comb begin
    if (!msg.end_of_message || (msg.valid_bytes >= sha256mh_pkg::FULL_WORD_BYTES)) begin
      nb_eff = sha256mh_pkg::FULL_WORD_BYTES;
    end else begin
      nb_eff = msg.valid_bytes;
    end
    keep_mask = ~(32'hffff_ffff >> {nb_eff[1:0], 3'b000});
    marker = sha256mh_pkg::PAD_MARKER >> {nb_eff[1:0], 3'b000};
    if (nb_eff == sha256mh_pkg::FULL_WORD_BYTES) begin
      msg_word = msg.message_word;
    end else begin
      msg_word = (msg.message_word & keep_mask) | marker;
    end
  end

  always_comb begin
    unique case (cmd.pad_sel)
      sha256mh_pkg::PAD_ZERO:   pad_word = '0;
      sha256mh_pkg::PAD_MARK:   pad_word = sha256mh_pkg::PAD_MARKER;
      sha256mh_pkg::PAD_LEN_HI: pad_word = bit_count[63:32];
      sha256mh_pkg::PAD_LEN_LO: pad_word = bit_count[31:0];
      default:                  pad_word = '0;
    endcase
  end

  assign push = cmd.push_msg || cmd.push_pad;
  assign push_word = cmd.push_msg ? msg_word : pad_word;

  assign status.pos_14 = (pos == 4'd14);
  assign status.pos_15 = (pos == 4'd15);
  assign hash_word = hash[cmd.out_index];

  always_comb begin
    t1 = vars[7] + sha256mh_pkg::big_sigma1(vars[4])
       + ((vars[4] & vars[5]) ^ (~vars[4] & vars[6]))
       + sha256mh_pkg::K_TABLE[cmd.round_idx] + sched[0];
    t2 = sha256mh_pkg::big_sigma0(vars[0])
       + ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
    sched_new = sha256mh_pkg::small_sigma1(sched[14]) + sched[9]
              + sha256mh_pkg::small_sigma0(sched[1]) + sched[0];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      sched[pos] <= push_word;
    end else if (cmd.round_en) begin
      for (int i = 0; i < sha256mh_pkg::BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[sha256mh_pkg::BLOCK_WORDS - 1] <= sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (push && (pos == 4'd15)) begin
      for (int i = 0; i < sha256mh_pkg::HASH_WORDS; i++) begin
        vars[i] <= hash[i];
      end
    end else if (cmd.round_en) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_hash) begin
      for (int i = 0; i < sha256mh_pkg::HASH_WORDS; i++) begin
        hash[i] <= sha256mh_pkg::IV_TABLE[i];
      end
      pos <= '0;
      bit_count <= '0;
    end else begin
      if (cmd.update_hash) begin
        for (int i = 0; i < sha256mh_pkg::HASH_WORDS; i++) begin
          hash[i] <= hash[i] + vars[i];
        end
      end
      if (push) begin
        pos <= pos + 4'd1;
      end
      if (cmd.push_msg) begin
        bit_count <= bit_count + {58'b0, nb_eff, 3'b000};
      end
    end
  end

endmodule

/* src/sha256_message_hasher_top.sv */
// Top level of the SHA-256 message hasher: controller plus datapath.
// Depends on sha256mh_pkg, sha256mh_ctrl and sha256mh_datapath.
// Message words are accepted only while idle; after the last word of a block the
// shared round unit runs the compression rounds and the hash update, and no word is taken.
// After the last word of a message: padding, one or two compressions,
// then eight digest transfers, one per cycle while digest_ready is high.
// Synchronous active-high reset returns to idle with the initial hash and a zero count.
module sha256_message_hasher_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_ready,
  input  sha256mh_pkg::msg_t    msg,
  output logic                  digest_valid,
  input  logic                  digest_ready,
  output sha256mh_pkg::digest_t digest
);

  sha256mh_pkg::ctrl_cmd_t  cmd;
  sha256mh_pkg::dp_status_t status;
  logic [31:0]              hash_word;

  sha256mh_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .msg_valid    (msg_valid),
    .msg          (msg),
    .msg_ready    (msg_ready),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .status       (status),
    .cmd          (cmd)
  );

  sha256mh_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .cmd       (cmd),
    .status    (status),
    .hash_word (hash_word)
  );

  assign digest.digest_word = hash_word;
  assign digest.digest_index = cmd.out_index;
  assign digest.digest_done = (cmd.out_index == sha256mh_pkg::DIGEST_LAST);

endmodule

/* src/sha256mh_checker.sv */
// Port-level checker for the SHA-256 message hasher, bound to the top level.
// Depends on sha256mh_pkg and sha256_message_hasher_top.
module sha256mh_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  msg_valid,
  input logic                  msg_ready,
  input sha256mh_pkg::msg_t    msg,
  input logic                  digest_valid,
  input logic                  digest_ready,
  input sha256mh_pkg::digest_t digest
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("Input accepted while digest is being delivered.");

  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (digest.digest_done == (digest.digest_index == sha256mh_pkg::DIGEST_LAST)))
    else $error("Digest done flag does not match the last index.");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && !digest.digest_done)
      |=> (digest_valid && (digest.digest_index == $past(digest.digest_index) + 3'd1)))
    else $error("Digest burst broke off or skipped a word.");

  a_burst_ends: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && digest.digest_done) |=> (!digest_valid && msg_ready))
    else $error("Hasher did not return to idle after the last digest word.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_ready) |=> (digest_valid && $stable(digest)))
    else $error("Digest changed while stalled.");

endmodule

bind sha256_message_hasher_top sha256mh_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .msg_valid    (msg_valid),
  .msg_ready    (msg_ready),
  .msg          (msg),
  .digest_valid (digest_valid),
  .digest_ready (digest_ready),
  .digest       (digest)
);
